// ===== sv/mfle_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the monochrome framebuffer line engine.
package mfle_pkg;

    typedef enum logic [2:0] {
        OP_SET    = 3'd0,
        OP_CLEAR  = 3'd1,
        OP_LINE   = 3'd2,
        OP_SCROLL = 3'd3,
        OP_READ   = 3'd4
    } op_t;

    localparam int COORD_W = 8;
    localparam int PAGE_W  = 3;
    localparam int BYTE_W  = 8;

    typedef struct packed {
        logic [2:0]         op;
        logic [COORD_W-1:0] xa;
        logic [COORD_W-1:0] ya;
        logic [COORD_W-1:0] xb;
        logic [COORD_W-1:0] yb;
        logic [PAGE_W-1:0]  read_page;
    } cmd_t;

    typedef struct packed {
        logic [BYTE_W-1:0] byte_out;
    } rsp_t;

endpackage

// ===== sv/mfle_stream_if.sv =====
`timescale 1ns / 1ps
// Valid/ready stream interface with a generic payload type.
interface mfle_stream_if #(parameter type payload_t = logic [7:0]);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== sv/mfle_ram.sv =====
`timescale 1ns / 1ps
// Generic single-port synchronous RAM with a registered read.
module mfle_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

// ===== sv/mono_framebuffer_line_engine_core.sv =====
`timescale 1ns / 1ps
// Top level of the monochrome framebuffer line engine.
//
//  Channel    Direction  Payload
//  cmd        sink       op, xa, ya, xb, yb, read_page
//  rsp        source     byte_out
//  cfg        write      halve_sample (cfg_we, cfg_wdata)
//
// One item at a time. Set and clear read the target byte, modify it and write it
// back before the result beat; a read captures the addressed byte. A line runs
// each major-axis step through the serial divider; a scroll reads and writes
// every byte through the single memory port. After reset a clearing pass
// over the whole memory runs before the first command is taken. A stalled
// result blocks new items.
module mono_framebuffer_line_engine_core #(
    parameter int PAGES   = 8,
    parameter int COLUMNS = 128,
    parameter int ROWS    = 64
) (
    input  logic          clk,
    input  logic          rst_n,
    mfle_stream_if.sink   cmd,
    mfle_stream_if.source rsp,
    input  logic          cfg_we,
    input  logic          cfg_wdata
);
    import mfle_pkg::*;

    localparam int DEPTH  = PAGES * COLUMNS;
    localparam int AW     = $clog2(DEPTH);
    localparam int CW     = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
    localparam int PW     = (PAGES > 1) ? $clog2(PAGES) : 1;
    localparam int DIV_W  = 2 * COORD_W;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_PT_RD, S_PT_WAIT, S_PT_WR, S_LN_DIV, S_LN_PT,
        S_SC_RD, S_SC_WR, S_RD_WAIT, S_RD_CAP, S_RESP
    } state_t;

    state_t             state_reg;
    logic               halve_reg;
    logic [AW-1:0]      addr_reg;
    logic [AW:0]        sweep_reg;
    logic [CW-1:0]      col_reg;
    logic [2:0]         op_reg;
    logic [COORD_W-1:0] x1_reg, y1_reg;
    logic [COORD_W-1:0] dmaj_reg, dmin_reg;
    logic               xmaj_reg, xup_reg, yup_reg, set_reg;
    logic [COORD_W:0]   k_reg;
    logic [COORD_W-1:0] px_reg, py_reg;
    logic [DIV_W-1:0]   num_reg;
    logic [COORD_W:0]   rem_reg;
    logic [COORD_W-1:0] quo_reg;
    logic [4:0]         dcnt_reg;
    logic [BYTE_W-1:0]  mask_reg, out_reg;
    logic               ok_reg;

    logic              we;
    logic [AW-1:0]     addr;
    logic [BYTE_W-1:0] wdata, rdata;

    mfle_ram #(.WIDTH(BYTE_W), .DEPTH(DEPTH)) u_ram (
        .clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
    );

    // Pixel mapping for the point held in px_reg/py_reg.
    logic          pix_ok;
    logic [AW-1:0] pix_addr;
    logic [BYTE_W-1:0] pix_mask;
    always_comb
    begin
        pix_ok = (32'(px_reg) < COLUMNS) && (32'(py_reg) < ROWS)
            && (32'(py_reg >> 3) < PAGES);
        pix_addr = AW'((PAGES - 1 - int'(py_reg >> 3)) * COLUMNS + int'(px_reg));
        pix_mask = BYTE_W'(8'h80 >> py_reg[2:0]);
    end

    // Major coordinate from the step count, minor coordinate from the divider quotient.
    logic [COORD_W-1:0] maj_c, min_c;
    always_comb
    begin
        if (xmaj_reg)
        begin
            maj_c = xup_reg ? x1_reg + k_reg[COORD_W-1:0] : x1_reg - k_reg[COORD_W-1:0];
            min_c = yup_reg ? y1_reg + quo_reg : y1_reg - quo_reg;
        end
        else
        begin
            maj_c = yup_reg ? y1_reg + k_reg[COORD_W-1:0] : y1_reg - k_reg[COORD_W-1:0];
            min_c = xup_reg ? x1_reg + quo_reg : x1_reg - quo_reg;
        end
    end

    logic [COORD_W:0] rem_sh;
    assign rem_sh = {rem_reg[COORD_W-1:0], num_reg[DIV_W-1]};

    logic [COORD_W-1:0] dx_c, dy_c;
    assign dx_c = (cmd.data.xb > cmd.data.xa) ? cmd.data.xb - cmd.data.xa
                                              : cmd.data.xa - cmd.data.xb;
    assign dy_c = (cmd.data.yb > cmd.data.ya) ? cmd.data.yb - cmd.data.ya
                                              : cmd.data.ya - cmd.data.yb;

    assign cmd.ready = (state_reg == S_IDLE);
    assign rsp.valid = (state_reg == S_RESP);
    assign rsp.data.byte_out = out_reg;

    always_comb
    begin
        we    = 1'b0;
        addr  = addr_reg;
        wdata = '0;
        unique case (state_reg)
            S_CLEAR:
            begin
                we   = 1'b1;
                addr = sweep_reg[AW-1:0];
            end
            S_PT_WR:
            begin
                we    = ok_reg;
                wdata = set_reg ? (rdata | mask_reg) : (rdata & ~mask_reg);
            end
            S_SC_WR:
            begin
                we = 1'b1;
                if (col_reg == CW'(COLUMNS - 1))
                begin
                    wdata = ok_reg && (addr_reg == pix_addr) ? mask_reg : '0;
                end
                else
                begin
                    wdata = rdata;
                end
                addr = addr_reg;
            end
            S_SC_RD:
            begin
                addr = (col_reg == CW'(COLUMNS - 1)) ? addr_reg : addr_reg + 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            halve_reg <= 1'b0;
            sweep_reg <= '0;
            out_reg   <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                halve_reg <= cfg_wdata;
            end
            unique case (state_reg)
                S_CLEAR:
                begin
                    sweep_reg <= sweep_reg + 1'b1;
                    if (sweep_reg == (AW+1)'(DEPTH - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (cmd.valid)
                    begin
                        op_reg  <= cmd.data.op;
                        out_reg <= '0;
                        x1_reg  <= cmd.data.xa;
                        y1_reg  <= cmd.data.ya;
                        px_reg  <= cmd.data.xa;
                        py_reg  <= cmd.data.ya;
                        set_reg <= (cmd.data.op != OP_CLEAR);
                        case (cmd.data.op)
                            OP_SET, OP_CLEAR:
                            begin
                                state_reg <= S_PT_RD;
                            end
                            OP_LINE:
                            begin
                                xmaj_reg <= dx_c > dy_c;
                                dmaj_reg <= (dx_c > dy_c) ? dx_c : dy_c;
                                dmin_reg <= (dx_c > dy_c) ? dy_c : dx_c;
                                xup_reg  <= cmd.data.xb > cmd.data.xa;
                                yup_reg  <= cmd.data.yb > cmd.data.ya;
                                k_reg    <= '0;
                                quo_reg  <= '0;
                                state_reg <= S_LN_PT;
                            end
                            OP_SCROLL:
                            begin
                                px_reg <= COORD_W'(COLUMNS - 1);
                                py_reg <= halve_reg ? cmd.data.ya >> 1 : cmd.data.ya;
                                addr_reg  <= '0;
                                sweep_reg <= '0;
                                col_reg   <= '0;
                                state_reg <= S_SC_RD;
                            end
                            OP_READ:
                            begin
                                ok_reg <= (32'(cmd.data.xa) < COLUMNS)
                                    && (32'(cmd.data.read_page) < PAGES);
                                addr_reg <= AW'(int'(cmd.data.read_page) * COLUMNS
                                    + int'(cmd.data.xa));
                                state_reg <= S_RD_WAIT;
                            end
                            default:
                            begin
                                state_reg <= S_RESP;
                            end
                        endcase
                    end
                end
                S_LN_PT:
                begin
                    px_reg <= xmaj_reg ? maj_c : min_c;
                    py_reg <= xmaj_reg ? min_c : maj_c;
                    state_reg <= S_PT_RD;
                end
                S_PT_RD:
                begin
                    ok_reg    <= pix_ok;
                    mask_reg  <= pix_mask;
                    addr_reg  <= pix_addr;
                    state_reg <= S_PT_WAIT;
                end
                S_PT_WAIT:
                begin
                    state_reg <= S_PT_WR;
                end
                S_PT_WR:
                begin
                    if (op_reg == OP_LINE && k_reg[COORD_W-1:0] != dmaj_reg)
                    begin
                        k_reg    <= k_reg + 1'b1;
                        num_reg  <= DIV_W'((k_reg + 1'b1) * dmin_reg);
                        rem_reg  <= '0;
                        dcnt_reg <= '0;
                        state_reg <= S_LN_DIV;
                    end
                    else
                    begin
                        state_reg <= S_RESP;
                    end
                end
                S_LN_DIV:
                begin
                    // Restoring division, one quotient bit per cycle.
                    num_reg  <= num_reg << 1;
                    dcnt_reg <= dcnt_reg + 1'b1;
                    if (rem_sh >= {1'b0, dmaj_reg})
                    begin
                        rem_reg <= rem_sh - {1'b0, dmaj_reg};
                        quo_reg <= {quo_reg[COORD_W-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= rem_sh;
                        quo_reg <= {quo_reg[COORD_W-2:0], 1'b0};
                    end
                    if (dcnt_reg == 5'(DIV_W - 1))
                    begin
                        state_reg <= S_LN_PT;
                    end
                end
                S_SC_RD:
                begin
                    ok_reg    <= pix_ok;
                    mask_reg  <= pix_mask;
                    state_reg <= S_SC_WR;
                end
                S_SC_WR:
                begin
                    addr_reg  <= addr_reg + 1'b1;
                    sweep_reg <= sweep_reg + 1'b1;
                    col_reg   <= (col_reg == CW'(COLUMNS - 1)) ? '0 : col_reg + 1'b1;
                    if (sweep_reg == (AW+1)'(DEPTH - 1))
                    begin
                        state_reg <= S_RESP;
                    end
                    else
                    begin
                        state_reg <= S_SC_RD;
                    end
                end
                S_RD_WAIT:
                begin
                    state_reg <= S_RD_CAP;
                end
                S_RD_CAP:
                begin
                    out_reg   <= ok_reg ? rdata : '0;
                    state_reg <= S_RESP;
                end
                S_RESP:
                begin
                    if (rsp.ready)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |-> !cmd.ready)
        else $error("command taken during clearing pass");
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && !rsp.ready) |=> rsp.valid)
        else $error("result dropped while stalled");
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.valid && cmd.ready) |=> !cmd.ready)
        else $error("second command taken while busy");
endmodule
